### design/poly_synth_voice_mixer_macros.svh
// assertion macros for the voice mixer checker
`ifndef POLY_SYNTH_VOICE_MIXER_MACROS_SVH
`define POLY_SYNTH_VOICE_MIXER_MACROS_SVH

// same-cycle implication
`define PSVM_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSVM_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/psvm_pkg.sv
// shared constants, types and functions of the voice mixer
package psvm_pkg;

	localparam int VOICES        = 16;
	localparam int VID_W         = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SAMPLE_RATE   = 48000;
	localparam int FILTER_ATTACK = 0;
	localparam int SUM_W         = 49 + VID_W;
	localparam int CFG_W         = 3;
	localparam int CFG_DATA_W    = 16;
	localparam logic [17:0] ENV_MAX = 18'h3FFFF;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_ON     = 2'd1;
	localparam logic [1:0] ACT_OFF    = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [CFG_W-1:0] CFG_WAVE_DUTY   = 3'd0;
	localparam logic [CFG_W-1:0] CFG_AMP_ATTACK  = 3'd1;
	localparam logic [CFG_W-1:0] CFG_AMP_DECAY   = 3'd2;
	localparam logic [CFG_W-1:0] CFG_AMP_SUSTAIN = 3'd3;
	localparam logic [CFG_W-1:0] CFG_FLT_DECAY   = 3'd4;
	localparam logic [CFG_W-1:0] CFG_FLT_SUSTAIN = 3'd5;
	localparam logic [CFG_W-1:0] CFG_CUTOFF      = 3'd6;
	localparam logic [CFG_W-1:0] CFG_RESONANCE   = 3'd7;

	// octave-3 semitone frequencies, Q8.16 Hz
	localparam logic [23:0] SEMITONE [12] = '{
		24'd8572947, 24'd9082720, 24'd9622807, 24'd10195009,
		24'd10801236, 24'd11443511, 24'd12123977, 24'd12844906,
		24'd13608704, 24'd14417920, 24'd15275254, 24'd16183568
	};

	typedef struct packed {
		logic               gate;
		logic [6:0]         pitch;
		logic [15:0]        gain;
		logic [31:0]        phase;
		logic [17:0]        env;
		logic signed [31:0] low;
		logic signed [31:0] band;
	} voice_t;

	typedef struct packed {
		logic        start;
		logic [15:0] num;
		logic [15:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] quo;
	} div_rsp_t;

	// phase increment per tick, evaluated at elaboration only
	function automatic logic [31:0] phase_inc(input logic [6:0] p);
		logic [63:0] inc;
		int oct;
		int k;
		oct = int'(p) / 12;
		k   = int'(p) % 12;
		inc = (64'(SEMITONE[k]) << (12 + oct)) / 64'(SAMPLE_RATE);
		return inc[31:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767)
			return 16'sh7FFF;
		else if (v < -64'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

### design/poly_synth_voice_mixer.sv
// top level of the sixteen-voice subtractive synthesizer mixer
// The block holds every voice (gate, pitch, gain, phase, envelope count and
// the two filter integrators) in one ram entry and visits the voices one at
// a time. A note-on or note-off beat reads its voice entry in S_NRD and
// writes it back in S_NWR. A sample tick walks all voices in order; each
// voice is read, passes two 17-step envelope divisions on the shared divider
// and the filter states, and is written back in S_F5 before the next voice;
// the tick's sample is offered after the last voice. Items are taken one at a
// time: in_stall is high from acceptance until the item is done. The output
// sample sits in its own register, so a new item is taken while a sample
// still waits; a tick that finishes before that sample leaves holds at its
// end until the output register frees. Configuration must be written only
// while the block is idle. Ram entries never written read as zero through a
// per-voice valid bit cleared by reset.
module poly_synth_voice_mixer (
	input  logic                               clk,
	input  logic                               arst_n,
	// item channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         action,
	input  logic [3:0]                         voice,
	input  logic [6:0]                         pitch,
	input  logic [15:0]                        volume,
	// sample channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [15:0]                 sample,
	// configuration write port
	input  logic                               cfg_wr,
	input  logic [psvm_pkg::CFG_W-1:0]         cfg_index,
	input  logic [psvm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int VID_W = psvm_pkg::VID_W;
	localparam int ENT_W = $bits(psvm_pkg::voice_t);
	localparam logic [15:0] FLT_ATT = 16'(psvm_pkg::FILTER_ATTACK);

	typedef enum logic [16:0] {
		S_IDLE = 17'h00001,
		S_NRD  = 17'h00002,
		S_NWR  = 17'h00004,
		S_VRD  = 17'h00008,
		S_VLD  = 17'h00010,
		S_ASET = 17'h00020,
		S_ADIV = 17'h00040,
		S_FSET = 17'h00080,
		S_FDIV = 17'h00100,
		S_CUB1 = 17'h00200,
		S_CUB2 = 17'h00400,
		S_COEF = 17'h00800,
		S_F1   = 17'h01000,
		S_F2   = 17'h02000,
		S_F3   = 17'h04000,
		S_F4   = 17'h08000,
		S_F5   = 17'h10000
	} state_t;

	// the output handoff shares S_F5's last-voice exit with a wait state
	typedef enum logic [1:0] {
		O_RUN  = 2'b01,
		O_HOLD = 2'b10
	} hold_t;

	// configuration registers
	logic [7:0]  wave_duty_q;
	logic [15:0] amp_attack_q, amp_decay_q, amp_sustain_q;
	logic [15:0] flt_decay_q, flt_sustain_q, cutoff_q, resonance_q;

	// control
	state_t                state_q;
	hold_t                 hold_q;
	logic [VID_W-1:0]      vcnt_q;
	logic                  vld_q [psvm_pkg::VOICES];
	logic                  out_valid_q;

	// item and voice datapath
	logic [VID_W-1:0]           vid_q;
	logic [1:0]                 act_q;
	logic [6:0]                 pitch_q;
	logic [15:0]                vol_q;
	psvm_pkg::voice_t           cur_q;
	logic                       amp_att_q, flt_att_q;
	logic signed [20:0]         drive_q;
	logic [15:0]                fl_q;
	logic [31:0]                sq_q;
	logic [15:0]                coef_q;
	logic signed [48:0]         plo_q;
	logic signed [49:0]         pdm_q;
	logic signed [31:0]         lo_q;
	logic signed [35:0]         high_q;
	logic signed [52:0]         phi_q;
	logic signed [48:0]         pmix_q;
	logic signed [psvm_pkg::SUM_W-1:0] sum_q;
	logic signed [15:0]         sample_q;

	// ram port
	logic             ram_re, ram_we;
	logic [VID_W-1:0] ram_raddr, ram_waddr;
	logic [ENT_W-1:0] ram_rdata, ram_wdata;
	psvm_pkg::voice_t ent, note_ent, wb_ent;

	// divider
	psvm_pkg::div_req_t div_req;
	psvm_pkg::div_rsp_t div_rsp;

	// phase increment table, one entry per midi note
	logic [31:0] inc_tab [128];
	for (genvar g = 0; g < 128; g++) begin : g_inc
		assign inc_tab[g] = psvm_pkg::phase_inc(7'(g));
	end

	logic voice_ok;
	logic last_voice;
	logic in_acc;

	assign in_stall   = (state_q != S_IDLE) || (hold_q != O_RUN);
	assign in_acc     = in_valid && !in_stall;
	assign voice_ok   = 32'(voice) < 32'(psvm_pkg::VOICES);
	assign last_voice = vcnt_q == VID_W'(psvm_pkg::VOICES - 1);

	// ram read and write selection, note address held through its write-back
	assign ram_re    = (state_q == S_NRD) || (state_q == S_VRD);
	assign ram_raddr = ((state_q == S_NRD) || (state_q == S_NWR)) ? vid_q : vcnt_q;
	assign ent       = (vld_q[ram_raddr]) ? psvm_pkg::voice_t'(ram_rdata) : '0;

	always_comb begin
		note_ent = ent;
		if (act_q == psvm_pkg::ACT_ON) begin
			note_ent.gate  = 1'b1;
			note_ent.pitch = pitch_q;
			note_ent.gain  = vol_q;
			note_ent.env   = '0;
		end else begin
			note_ent.gate = 1'b0;
		end
	end

	logic signed [63:0] band_sum;
	assign band_sum = 64'($signed(cur_q.band)) + 64'(phi_q >>> 16);

	always_comb begin
		wb_ent      = cur_q;
		wb_ent.low  = lo_q;
		wb_ent.band = psvm_pkg::sat32(band_sum);
	end

	assign ram_we    = (state_q == S_NWR) || (state_q == S_F5);
	assign ram_waddr = (state_q == S_NWR) ? vid_q : vcnt_q;
	assign ram_wdata = (state_q == S_NWR) ? ENT_W'(note_ent) : ENT_W'(wb_ent);

	psvm_ram #(
		.W (ENT_W),
		.D (psvm_pkg::VOICES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// amplitude envelope operands: attack ramp, else decay toward sustain
	logic        a_in_att;
	logic [15:0] a_dec;
	logic [17:0] a_t;
	logic [15:0] a_num, a_den;

	assign a_in_att = cur_q.env < 18'(amp_attack_q);
	assign a_dec    = (amp_decay_q == 16'd0) ? 16'd1 : amp_decay_q;
	assign a_t      = cur_q.env - 18'(amp_attack_q);
	assign a_num    = a_in_att ? cur_q.env[15:0] :
		((a_t < 18'(a_dec)) ? (a_dec - a_t[15:0]) : 16'd0);
	assign a_den    = a_in_att ? amp_attack_q : a_dec;

	// filter envelope operands, same shape with a fixed attack length
	logic        f_in_att;
	logic [15:0] f_dec;
	logic [17:0] f_t;
	logic [15:0] f_num, f_den;

	assign f_in_att = cur_q.env < 18'(FLT_ATT);
	assign f_dec    = (flt_decay_q == 16'd0) ? 16'd1 : flt_decay_q;
	assign f_t      = cur_q.env - 18'(FLT_ATT);
	assign f_num    = f_in_att ? cur_q.env[15:0] :
		((f_t < 18'(f_dec)) ? (f_dec - f_t[15:0]) : 16'd0);
	assign f_den    = f_in_att ? FLT_ATT : f_dec;

	always_comb begin
		div_req.start = (state_q == S_ASET) || (state_q == S_FSET);
		div_req.num   = (state_q == S_FSET) ? f_num : a_num;
		div_req.den   = (state_q == S_FSET) ? f_den : a_den;
	end

	psvm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// quotient saturated to q0.16, decay branch floored at sustain
	logic [15:0] q_sat, amp_lvl, flt_lvl;
	assign q_sat   = div_rsp.quo[16] ? 16'hFFFF : div_rsp.quo[15:0];
	assign amp_lvl = (!amp_att_q && (q_sat < amp_sustain_q)) ? amp_sustain_q : q_sat;
	assign flt_lvl = (!flt_att_q && (q_sat < flt_sustain_q)) ? flt_sustain_q : q_sat;

	// oscillator: saw, or square against the duty threshold
	logic [15:0]        p16;
	logic signed [16:0] wave;
	logic signed [33:0] wprod;

	assign p16   = cur_q.phase[31:16];
	always_comb begin
		if (wave_duty_q == 8'd0)
			wave = $signed({1'b0, p16}) - 17'sd32768;
		else if ({1'b0, p16} >= (17'h10000 - {1'b0, wave_duty_q, 8'h00}))
			wave = 17'sd32768 - 17'sd1 + 17'sd1;
		else
			wave = -17'sd32768;
	end
	assign wprod = wave * $signed({1'b0, amp_lvl});

	logic [16:0]        damp;
	logic signed [63:0] lo_sum;
	assign damp   = 17'h10000 - {1'b0, resonance_q};
	assign lo_sum = 64'($signed(cur_q.low)) + 64'(plo_q >>> 16);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_duty_q   <= 8'd0;
			amp_attack_q  <= 16'd0;
			amp_decay_q   <= 16'd4096;
			amp_sustain_q <= 16'd26214;
			flt_decay_q   <= 16'd4096;
			flt_sustain_q <= 16'd26214;
			cutoff_q      <= 16'd6554;
			resonance_q   <= 16'd19661;
		end else if (cfg_wr) begin
			case (cfg_index)
				psvm_pkg::CFG_WAVE_DUTY:   wave_duty_q   <= cfg_data[7:0];
				psvm_pkg::CFG_AMP_ATTACK:  amp_attack_q  <= cfg_data;
				psvm_pkg::CFG_AMP_DECAY:   amp_decay_q   <= cfg_data;
				psvm_pkg::CFG_AMP_SUSTAIN: amp_sustain_q <= cfg_data;
				psvm_pkg::CFG_FLT_DECAY:   flt_decay_q   <= cfg_data;
				psvm_pkg::CFG_FLT_SUSTAIN: flt_sustain_q <= cfg_data;
				psvm_pkg::CFG_CUTOFF:      cutoff_q      <= cfg_data;
				psvm_pkg::CFG_RESONANCE:   resonance_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hold_q      <= O_RUN;
			vcnt_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < psvm_pkg::VOICES; i++)
				vld_q[i] <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			// finished sample waiting for the output register
			if (hold_q == O_HOLD && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
				hold_q      <= O_RUN;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (action == psvm_pkg::ACT_TICK) begin
							vcnt_q  <= '0;
							state_q <= S_VRD;
						end else if ((action == psvm_pkg::ACT_ON ||
							action == psvm_pkg::ACT_OFF) && voice_ok) begin
							state_q <= S_NRD;
						end
					end
				end
				S_NRD:  state_q <= S_NWR;
				S_NWR: begin
					vld_q[vid_q] <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_VRD:  state_q <= S_VLD;
				S_VLD:  state_q <= S_ASET;
				S_ASET: state_q <= S_ADIV;
				S_ADIV: begin
					if (div_rsp.done)
						state_q <= S_FSET;
				end
				S_FSET: state_q <= S_FDIV;
				S_FDIV: begin
					if (div_rsp.done)
						state_q <= S_CUB1;
				end
				S_CUB1: state_q <= S_CUB2;
				S_CUB2: state_q <= S_COEF;
				S_COEF: state_q <= S_F1;
				S_F1:   state_q <= S_F2;
				S_F2:   state_q <= S_F3;
				S_F3:   state_q <= S_F4;
				S_F4:   state_q <= S_F5;
				S_F5: begin
					vld_q[vcnt_q] <= 1'b1;
					if (last_voice) begin
						hold_q  <= O_HOLD;
						state_q <= S_IDLE;
					end else begin
						vcnt_q  <= vcnt_q + VID_W'(1);
						state_q <= S_VRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			vid_q   <= VID_W'(voice);
			act_q   <= action;
			pitch_q <= pitch;
			vol_q   <= volume;
			sum_q   <= '0;
		end
		case (state_q)
			S_VLD: begin
				cur_q <= ent;
				if (ent.gate) begin
					cur_q.phase <= ent.phase + inc_tab[ent.pitch];
					cur_q.env   <= (ent.env == psvm_pkg::ENV_MAX) ? ent.env :
						ent.env + 18'd1;
				end
			end
			S_ASET: amp_att_q <= a_in_att;
			S_ADIV: begin
				if (div_rsp.done)
					drive_q <= cur_q.gate ? wprod[33:13] : '0;
			end
			S_FSET: flt_att_q <= f_in_att;
			S_FDIV: begin
				if (div_rsp.done)
					fl_q <= flt_lvl;
			end
			S_CUB1: sq_q <= 32'(fl_q) * 32'(fl_q);
			S_CUB2: begin
				// cube only on the decay side
				if (!flt_att_q)
					fl_q <= 16'((48'(sq_q) * 48'(fl_q)) >> 32);
			end
			S_COEF: coef_q <= 16'((32'(fl_q) * 32'(cutoff_q)) >> 16);
			S_F1: begin
				plo_q <= $signed({1'b0, coef_q}) * $signed(cur_q.band);
				pdm_q <= $signed({1'b0, damp}) * $signed(cur_q.band);
			end
			S_F2: lo_q <= psvm_pkg::sat32(lo_sum);
			S_F3: high_q <= 36'(drive_q) - 36'(lo_q) - 36'(pdm_q >>> 16);
			S_F4: begin
				phi_q  <= $signed({1'b0, coef_q}) * high_q;
				pmix_q <= lo_q * $signed({1'b0, cur_q.gain});
			end
			S_F5: sum_q <= sum_q + psvm_pkg::SUM_W'(pmix_q);
			default: ;
		endcase
		if (hold_q == O_HOLD && (!out_valid_q || !out_stall))
			sample_q <= psvm_pkg::sat16(64'(sum_q >>> 21));
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule

### design/psvm_ram.sv
// generic single-port-write ram with registered read
module psvm_ram #(
	parameter int W = 8,
	parameter int D = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### design/psvm_div.sv
// iterative divider for envelope levels: quo = (num << 16) / den, num <= den
module psvm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  psvm_pkg::div_req_t  req,
	output psvm_pkg::div_rsp_t  rsp
);

	logic [16:0] rem_q;
	logic [15:0] den_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        ge;
	logic [16:0] rem_sub;

	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_sub[15:0], 1'b0};
			quo_q <= {quo_q[15:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### design/psvm_checker.sv
// port-level checker for the voice mixer, bound to the top level
`include "poly_synth_voice_mixer_macros.svh"

module psvm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [1:0]        action,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [15:0] sample
);

	`PSVM_AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample), "sample beat changed while stalled")
	`PSVM_AST_NEXT(a_busy_after_accept, in_valid && !in_stall && action != psvm_pkg::ACT_UNUSED, in_stall, "item accepted while previous still in work")
	`PSVM_AST_NOW(a_sample_from_work, $rose(out_valid), $past(in_stall), "sample appeared without tick work")
	`PSVM_AST_NEXT(a_note_no_sample, in_valid && !in_stall && action != psvm_pkg::ACT_TICK, !$rose(out_valid), "non-tick item produced a sample")

endmodule

bind poly_synth_voice_mixer psvm_checker u_psvm_checker (.*);
